// ===== hdl/oft_pkg.sv =====
// Order fill table engine package: command, status, state codes, widths, slot record.
// Depends on nothing; used by every module of the engine.
package oft_pkg;

  typedef enum logic [2:0] {
    KIND_SUBMIT = 3'd0,
    KIND_CANCEL = 3'd1,
    KIND_BOOK   = 3'd2,
    KIND_TRADE  = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_PENDING   = 2'd0,
    ST_PARTIAL   = 2'd1,
    ST_FILLED    = 2'd2,
    ST_CANCELLED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_FEE,
    S_DONE
  } state_e;

  localparam int unsigned PriceW = 24;
  localparam int unsigned FeeW   = 63;
  localparam int unsigned TakerW = 14;
  localparam logic [FeeW-1:0] FeeMax = {FeeW{1'b1}};

  // One table entry as held in the slot memory.
  typedef struct packed {
    logic              side;
    logic              otype;
    logic [PriceW-1:0] limit;
    logic [PriceW-1:0] size;
    logic [PriceW:0]   filled;
    status_e           status;
  } slot_t;

endpackage

// ===== hdl/oft_slot_mem.sv =====
// Slot memory of the order fill table engine: one write port, one registered read port.
// Depends on oft_pkg for the slot record.
module oft_slot_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  oft_pkg::slot_t      wdata_i,
  input  logic [AddrW-1:0]    raddr_i,
  output oft_pkg::slot_t      rdata_o
);

  oft_pkg::slot_t mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/oft_fee_unit.sv =====
// Fee unit: price times lots in one stage, times taker fee in the next, then saturating add.
// Depends on oft_pkg for widths and the saturation limit.
module oft_fee_unit (
  input  logic                             clk_i,
  input  logic [oft_pkg::PriceW-1:0]       px_i,
  input  logic [oft_pkg::PriceW-1:0]       sz_i,
  input  logic [oft_pkg::TakerW-1:0]       fee_i,
  input  logic [oft_pkg::FeeW-1:0]         sum_i,
  output logic [oft_pkg::FeeW-1:0]         sum_o
);

  localparam int unsigned FullW = 2*oft_pkg::PriceW + oft_pkg::TakerW;

  logic [2*oft_pkg::PriceW-1:0]                 prod_q;
  logic [FullW-1:0]                             fee_full;
  logic [oft_pkg::FeeW:0]                       add;

  // First stage: price times lots.
  always_ff @(posedge clk_i) begin
    prod_q <= px_i * sz_i;
  end

  // Second product is read in the following cycle and saturated into the sum.
  assign fee_full = prod_q * fee_i;
  assign add = {1'b0, sum_i} + {{(oft_pkg::FeeW + 1 - FullW){1'b0}}, fee_full};
  assign sum_o = add[oft_pkg::FeeW] ? oft_pkg::FeeMax : add[oft_pkg::FeeW-1:0];

endmodule

// ===== hdl/order_fill_table_engine.sv =====
// Top level of the order fill table engine: command sequencer around the slot memory and fee unit.
// Depends on oft_pkg, oft_slot_mem and oft_fee_unit.
//
//  channel   handshake             payload
//  command   start / busy          kind_i .. best_ask_i
//  result    res_valid_o (strobe)  result_id_o .. last_o
//  config    cfg_valid_i/cfg_ready_o  cfg_data_i (taker fee)
//
// Submit and clear finish in the read state and cancel in the evaluate state. Book update
// and trade visit each slot in turn: memory read and evaluate for a skipped slot, plus fee
// multiply with write back for a filled slot. Reset clears the used bits, next id, fee sum
// and sets the fee to 200. Results cannot be stalled; busy is high from acceptance until the
// last result strobe, except after a walk that ends on a fill, where the closing result shows
// in the first idle cycle.
module order_fill_table_engine #(
  parameter int unsigned ORDER_SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind_i,
  input  logic        side_i,
  input  logic        order_type_i,
  input  logic [23:0] price_i,
  input  logic [23:0] quantity_i,
  input  logic [4:0]  target_id_i,
  input  logic [23:0] best_bid_i,
  input  logic [23:0] best_ask_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [13:0] cfg_data_i,
  output logic        res_valid_o,
  output logic [4:0]  result_id_o,
  output logic        ok_o,
  output logic        is_fill_o,
  output logic [23:0] fill_price_o,
  output logic [23:0] fill_size_o,
  output logic [1:0]  order_status_o,
  output logic [62:0] fee_total_o,
  output logic        last_o
);

  localparam int unsigned AddrW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
  localparam int unsigned CntW  = $clog2(ORDER_SLOTS + 1);

  oft_pkg::state_e state_q, state_d;
  logic [ORDER_SLOTS-1:0]   used_q, used_d;
  logic [CntW-1:0]          next_q, next_d;
  logic [oft_pkg::FeeW-1:0] fee_q, fee_d, fee_new;
  logic [13:0]              taker_q;
  logic [2:0]               kind_q;
  logic                     side_q, otype_q;
  logic [23:0]              price_q, qty_q, bid_q, ask_q, px_q, sz_q;
  logic [4:0]               target_q;
  logic [CntW-1:0]          idx_q, idx_d;
  logic [AddrW-1:0]         raddr;
  logic                     we;
  logic [AddrW-1:0]         waddr;
  oft_pkg::slot_t           wdata, rdata, upd_q, upd_d;
  logic [23:0]              px_d, sz_d;
  logic                     go;
  logic [24:0]              rem;
  logic [24:0]              filled_new;
  logic                     tgt_ok;
  logic [AddrW-1:0]         tgt_idx;

  // Output register set.
  logic                     rv_d, rv_q, ok_d, ok_q, fill_d, fill_q, last_d, last_q;
  logic [4:0]               rid_d, rid_q;
  logic [23:0]              opx_d, opx_q, osz_d, osz_q;
  logic [1:0]               ost_d, ost_q;

  assign cfg_ready_o = 1'b1;
  assign busy = (state_q != oft_pkg::S_IDLE);
  assign tgt_ok = (target_q != 5'd0) && ({1'b0, target_q} <= 6'(ORDER_SLOTS));
  assign tgt_idx = AddrW'(target_q - 5'd1);

  oft_slot_mem #(.Depth(ORDER_SLOTS), .AddrW(AddrW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  oft_fee_unit u_fee (
    .clk_i (clk_i),
    .px_i  (px_d),
    .sz_i  (sz_d),
    .fee_i (taker_q),
    .sum_i (fee_q),
    .sum_o (fee_new)
  );

  // Fill decision for the slot just read.
  always_comb begin
    rem = (rdata.filled >= {1'b0, rdata.size}) ? 25'd0 : ({1'b0, rdata.size} - rdata.filled);
    go = 1'b0;
    px_d = 24'd0;
    sz_d = rem[23:0];
    if (kind_q == oft_pkg::KIND_BOOK) begin
      if (rdata.status == oft_pkg::ST_PENDING || rdata.status == oft_pkg::ST_PARTIAL) begin
        if (!rdata.otype) begin
          go = 1'b1;
          px_d = rdata.side ? bid_q : ask_q;
        end else if (!rdata.side) begin
          go = (ask_q != 24'd0) && (rdata.limit >= ask_q);
          px_d = ask_q;
        end else begin
          go = (bid_q != 24'd0) && (rdata.limit <= bid_q);
          px_d = bid_q;
        end
      end
    end else begin
      go = (rdata.status == oft_pkg::ST_PENDING) && !rdata.otype;
      px_d = price_q;
      if ({1'b0, qty_q} < rem) begin
        sz_d = qty_q;
      end
    end
    go = go && used_q[idx_q[AddrW-1:0]];
    filled_new = rdata.filled + {1'b0, sz_d};
  end

  // Sequencer: next state, memory access and results.
  always_comb begin
    state_d = state_q;
    used_d = used_q;
    next_d = next_q;
    fee_d = fee_q;
    idx_d = idx_q;
    raddr = idx_q[AddrW-1:0];
    we = 1'b0;
    waddr = idx_q[AddrW-1:0];
    wdata = upd_q;
    upd_d = upd_q;
    rv_d = 1'b0; ok_d = 1'b0; fill_d = 1'b0; last_d = 1'b0;
    rid_d = 5'd0; opx_d = 24'd0; osz_d = 24'd0; ost_d = 2'd0;
    case (state_q)
      oft_pkg::S_IDLE: begin
        if (start) begin
          state_d = oft_pkg::S_READ;
          idx_d = '0;
        end
      end
      oft_pkg::S_READ: begin
        // Address is set up; submit and clear finish here.
        case (kind_q)
          oft_pkg::KIND_SUBMIT: begin
            rv_d = 1'b1; last_d = 1'b1;
            if (next_q < CntW'(ORDER_SLOTS)) begin
              we = 1'b1;
              waddr = next_q[AddrW-1:0];
              wdata = '{side: side_q, otype: otype_q, limit: price_q, size: qty_q,
                        filled: 25'd0, status: oft_pkg::ST_PENDING};
              used_d[next_q[AddrW-1:0]] = 1'b1;
              next_d = next_q + CntW'(1);
              rid_d = 5'(next_q + CntW'(1));
              ok_d = 1'b1;
            end
            state_d = oft_pkg::S_DONE;
          end
          oft_pkg::KIND_CANCEL: begin
            raddr = tgt_idx;
            state_d = oft_pkg::S_EVAL;
          end
          oft_pkg::KIND_BOOK, oft_pkg::KIND_TRADE: begin
            state_d = oft_pkg::S_EVAL;
          end
          oft_pkg::KIND_CLEAR: begin
            used_d = '0; next_d = '0; fee_d = '0;
            rv_d = 1'b1; last_d = 1'b1;
            state_d = oft_pkg::S_DONE;
          end
          default: begin
            rv_d = 1'b1; last_d = 1'b1;
            state_d = oft_pkg::S_DONE;
          end
        endcase
      end
      oft_pkg::S_EVAL: begin
        if (kind_q == oft_pkg::KIND_CANCEL) begin
          rv_d = 1'b1; last_d = 1'b1;
          if (tgt_ok && used_q[tgt_idx] && (rdata.status == oft_pkg::ST_PENDING ||
              rdata.status == oft_pkg::ST_PARTIAL)) begin
            we = 1'b1;
            waddr = tgt_idx;
            wdata = rdata;
            wdata.status = oft_pkg::ST_CANCELLED;
            rid_d = target_q; ok_d = 1'b1; ost_d = oft_pkg::ST_CANCELLED;
          end
          state_d = oft_pkg::S_DONE;
        end else if (go) begin
          upd_d = rdata;
          upd_d.filled = filled_new;
          upd_d.status = (filled_new >= {1'b0, rdata.size}) ? oft_pkg::ST_FILLED
                                                            : oft_pkg::ST_PARTIAL;
          state_d = oft_pkg::S_FEE;
        end else if (idx_q == CntW'(ORDER_SLOTS - 1)) begin
          rv_d = 1'b1; last_d = 1'b1;
          state_d = oft_pkg::S_DONE;
        end else begin
          idx_d = idx_q + CntW'(1);
          state_d = oft_pkg::S_READ;
        end
      end
      oft_pkg::S_FEE: begin
        // Product is registered; write the slot back and report the fill.
        we = 1'b1;
        fee_d = fee_new;
        rv_d = 1'b1; fill_d = 1'b1;
        rid_d = 5'(idx_q + CntW'(1));
        opx_d = px_q; osz_d = sz_q; ost_d = upd_q.status;
        if (idx_q == CntW'(ORDER_SLOTS - 1)) begin
          state_d = oft_pkg::S_DONE;
          idx_d = CntW'(ORDER_SLOTS);
        end else begin
          idx_d = idx_q + CntW'(1);
          state_d = oft_pkg::S_READ;
        end
      end
      oft_pkg::S_DONE: begin
        // Closing result of a walk that ended on a fill.
        if (idx_q == CntW'(ORDER_SLOTS)) begin
          rv_d = 1'b1; last_d = 1'b1;
          idx_d = '0;
        end
        state_d = oft_pkg::S_IDLE;
      end
      default: state_d = oft_pkg::S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= oft_pkg::S_IDLE;
      used_q <= '0;
      next_q <= '0;
      fee_q <= '0;
      taker_q <= 14'd200;
      idx_q <= '0;
      rv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q <= used_d;
      next_q <= next_d;
      fee_q <= fee_d;
      idx_q <= idx_d;
      rv_q <= rv_d;
      if (cfg_valid_i && cfg_ready_o) begin
        taker_q <= cfg_data_i;
      end
    end
  end

  // Command capture, fill staging and result payload.
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      kind_q <= kind_i; side_q <= side_i; otype_q <= order_type_i;
      price_q <= price_i; qty_q <= quantity_i; target_q <= target_id_i;
      bid_q <= best_bid_i; ask_q <= best_ask_i;
    end
    if (state_q == oft_pkg::S_EVAL) begin
      px_q <= px_d;
      sz_q <= sz_d;
    end
    upd_q <= upd_d;
    ok_q <= ok_d; fill_q <= fill_d; last_q <= last_d;
    rid_q <= rid_d; opx_q <= opx_d; osz_q <= osz_d; ost_q <= ost_d;
  end

  assign res_valid_o    = rv_q;
  assign result_id_o    = rid_q;
  assign ok_o           = ok_q;
  assign is_fill_o      = fill_q;
  assign fill_price_o   = opx_q;
  assign fill_size_o    = osz_q;
  assign order_status_o = ost_q;
  assign fee_total_o    = fee_q;
  assign last_o         = last_q;

`ifndef SYNTH
  // No new command is taken while the engine is working.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("engine not busy after a command transfer");
  // The next id never passes the table size.
  a_next_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_q <= CntW'(ORDER_SLOTS))
    else $error("next id beyond table");
  // The fee sum only grows unless the table is cleared.
  a_fee_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == oft_pkg::S_FEE) |=> (fee_q >= $past(fee_q)))
    else $error("fee sum decreased on a fill");
  // A fill result is never the final one.
  a_fill_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && is_fill_o) |-> !last_o)
    else $error("fill marked last");
  // The final result is followed by a cycle without a result.
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && last_o) |=> !res_valid_o)
    else $error("result right after final result");
`endif

endmodule
